/* hdl/sgx_pkg.sv */
// Shared types, constants and helper functions for the stacking gap projector.
// Used by the arithmetic units and the top level; depends on nothing.
package sgx_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_IS_ABOVE   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAP_COMP   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ALIGN_COMP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP  = 3'd5;

	localparam int CFG_DATA_W = 32;
	localparam int MOB_W      = 25;
	localparam int COMP_W     = 31;
	localparam int STEP_W     = 17;

	// Shared unit sizes; the divisor holds a full 17-bit dt squared
	localparam int WIDE_W     = 64;
	localparam int MPL_W      = 32;
	localparam int DSR_W      = 34;
	localparam int MUL_STEPS  = MPL_W;
	localparam int DIV_STEPS  = WIDE_W;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (v > hi) return 32'sh7FFF_FFFF;
		else if (v < lo) return 32'sh8000_0000;
		else return v[31:0];
	endfunction

	// Product in Q32.32, optionally negated, truncated toward zero to Q16.16, saturated
	function automatic logic signed [31:0] corr(input logic signed [WIDE_W-1:0] p,
		input logic neg);
		logic signed [WIDE_W-1:0] v;
		logic signed [WIDE_W-1:0] t;
		v = neg ? -p : p;
		t = v >>> 16;
		if (v[WIDE_W-1] && (v[15:0] != 16'd0)) t = t + 64'sd1;
		return sat32(t);
	endfunction

endpackage

/* hdl/sgx_ifs.sv */
// Valid/ready channel interfaces for the stacking gap projector.
// Field widths match the item and result layouts; no package needed.
interface sgx_in_if;
	logic               valid;
	logic               ready;
	logic               clear_multipliers;
	logic [24:0]        inner_mobility;
	logic [24:0]        outer_mobility;
	logic signed [31:0] inner_top;
	logic signed [31:0] inner_bottom;
	logic signed [31:0] inner_center;
	logic signed [31:0] outer_top;
	logic signed [31:0] outer_bottom;
	logic signed [31:0] outer_center;

	modport source(output valid, clear_multipliers, inner_mobility, outer_mobility,
		inner_top, inner_bottom, inner_center, outer_top, outer_bottom, outer_center,
		input ready);
	modport sink(input valid, clear_multipliers, inner_mobility, outer_mobility,
		inner_top, inner_bottom, inner_center, outer_top, outer_bottom, outer_center,
		output ready);
endinterface

interface sgx_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] inner_dy_delta;
	logic signed [31:0] outer_dy_delta;
	logic signed [31:0] inner_dx_delta;
	logic signed [31:0] outer_dx_delta;
	logic               gap_violated;
	logic signed [31:0] gap_residual;

	modport source(output valid, inner_dy_delta, outer_dy_delta, inner_dx_delta,
		outer_dx_delta, gap_violated, gap_residual, input ready);
	modport sink(input valid, inner_dy_delta, outer_dy_delta, inner_dx_delta,
		outer_dx_delta, gap_violated, gap_residual, output ready);
endinterface

/* hdl/stack_gap_xpbd_projector.sv */
// Top level of the stacking gap projector: sequencer, state and config registers.
// Depends on sgx_pkg, sgx_ifs (channels), sgx_mul and sgx_div.
//
// One input transfer on in_ch is one compliant projection of a two-body
// constraint: a vertical gap inequality (multiplier clamped at zero) and a
// horizontal alignment equality. One result transfer on out_ch follows for
// every input transfer, carrying the dy/dx corrections and the gap residual.
// Configuration is written through wr_en / wr_index / wr_data, one register
// per cycle. The user must write it only while no projection is in flight;
// the block does not enforce this. The sequencer runs every product through
// the shared bit-serial multiplier and every quotient through the shared
// restoring divider: dt^2, two compliance terms, and for each active arm one
// product, one quotient and two corrections. Items with zero total mobility
// skip both arms.
// Throughput: one item at a time; in_ch.ready is high only in the idle state.
// A finished result waits in the output register; the next item is accepted
// meanwhile, and the sequencer holds its finish step while out_ch stalls.
// Reset clears both multipliers and loads the register defaults (outer above
// inner, zero gap, offset and compliances, unit time step).
module stack_gap_xpbd_projector (
	input  logic                                 clk,
	input  logic                                 arst_n,
	sgx_in_if.sink                               in_ch,
	sgx_out_if.source                            out_ch,
	input  logic                                 wr_en,
	input  logic [sgx_pkg::CFG_IDX_W-1:0]        wr_index,
	input  logic [sgx_pkg::CFG_DATA_W-1:0]       wr_data
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_DD, ST_AG, ST_AA, ST_GP, ST_GD, ST_GI, ST_GO,
		ST_XP, ST_XD, ST_XI, ST_XO, ST_OUT
	} state_t;

	localparam int W = sgx_pkg::WIDE_W;

	state_t state_q;
	logic   issued_q;

	// Configuration registers
	logic                              is_above_q;
	logic signed [31:0]                min_gap_q;
	logic signed [31:0]                offset_x_q;
	logic [sgx_pkg::COMP_W-1:0]        gap_comp_q;
	logic [sgx_pkg::COMP_W-1:0]        align_comp_q;
	logic [sgx_pkg::STEP_W-1:0]        time_step_q;

	// Multipliers (persistent state)
	logic signed [31:0]                gap_lam_q;
	logic signed [31:0]                align_lam_q;

	// Working registers of the current item
	logic [sgx_pkg::MOB_W-1:0]         wi_q;
	logic [sgx_pkg::MOB_W-1:0]         wo_q;
	logic signed [33:0]                c_q;
	logic signed [33:0]                ca_q;
	logic [sgx_pkg::DSR_W-1:0]         dd_q;
	logic [sgx_pkg::COMP_W-1:0]        alpha_g_q;
	logic [sgx_pkg::COMP_W-1:0]        alpha_a_q;
	logic signed [34:0]                dl_q;
	logic signed [31:0]                idy_q;
	logic signed [31:0]                ody_q;
	logic signed [31:0]                idx_q;
	logic signed [31:0]                odx_q;

	// Output register
	logic                              out_valid_q;
	logic signed [31:0]                o_idy_q;
	logic signed [31:0]                o_ody_q;
	logic signed [31:0]                o_idx_q;
	logic signed [31:0]                o_odx_q;
	logic                              o_viol_q;
	logic signed [31:0]                o_res_q;

	// Shared units
	logic                              mul_start;
	logic signed [W-1:0]               mul_mcand;
	logic [sgx_pkg::MPL_W-1:0]         mul_mplier;
	logic signed [W-1:0]               mul_prod;
	sgx_pkg::unit_stat_t               mul_stat;
	logic                              div_start;
	logic [W-1:0]                      div_dividend;
	logic [sgx_pkg::DSR_W-1:0]         div_divisor;
	logic [W-1:0]                      div_quot;
	sgx_pkg::unit_stat_t               div_stat;

	sgx_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (mul_mcand),
		.mplier (mul_mplier),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	sgx_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quot     (div_quot),
		.stat     (div_stat)
	);

	// Datapath around the units
	logic [sgx_pkg::STEP_W-1:0]        dt;
	logic [25:0]                       wsum;
	logic [sgx_pkg::DSR_W-1:0]         den_g;
	logic [sgx_pkg::DSR_W-1:0]         den_a;
	logic signed [W-1:0]               num;
	logic [W-1:0]                      num_abs;
	logic [33:0]                       q_mag;
	logic signed [34:0]                dl_new;
	logic signed [35:0]                lam_sum;
	logic signed [31:0]                lam_new;
	logic [sgx_pkg::COMP_W-1:0]        alpha_new;
	logic signed [33:0]                c_in;
	logic signed [33:0]                ca_in;
	logic                              in_fire;
	logic                              out_fire;
	logic                              out_load;
	logic                              arm_gap;

	assign dt    = (time_step_q == '0) ? sgx_pkg::STEP_W'(1) : time_step_q;
	assign wsum  = {1'b0, wi_q} + {1'b0, wo_q};
	assign den_g = {8'd0, wsum} + {3'd0, alpha_g_q};
	assign den_a = {8'd0, wsum} + {3'd0, alpha_a_q};

	// Gap arm in its product and quotient states, alignment arm otherwise
	assign arm_gap = (state_q == ST_GP) || (state_q == ST_GD);

	// Numerator in Q32.32: -(C << 16) - alpha * lambda, product held by the multiplier
	assign num     = -({{14{arm_gap ? c_q[33] : ca_q[33]}}, (arm_gap ? c_q : ca_q), 16'd0})
		- mul_prod;
	assign num_abs = num[W-1] ? W'(-num) : W'(num);

	// Quotient magnitude clamped to 2^33, then signed
	assign q_mag   = (div_quot > W'(64'h2_0000_0000)) ? 34'h2_0000_0000 : div_quot[33:0];
	assign dl_new  = num[W-1] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
	assign lam_sum = (arm_gap ? {{4{gap_lam_q[31]}}, gap_lam_q}
		: {{4{align_lam_q[31]}}, align_lam_q}) + {dl_new[34], dl_new};
	assign lam_new = sgx_pkg::sat32({{28{lam_sum[35]}}, lam_sum});

	// Compliance term saturates to the largest positive Q16.16
	assign alpha_new = (div_quot > W'(64'h7FFF_FFFF)) ? '1 : div_quot[sgx_pkg::COMP_W-1:0];

	assign c_in = is_above_q
		? ({{2{in_ch.outer_bottom[31]}}, in_ch.outer_bottom}
			- {{2{in_ch.inner_top[31]}}, in_ch.inner_top}
			- {{2{min_gap_q[31]}}, min_gap_q})
		: ({{2{in_ch.inner_bottom[31]}}, in_ch.inner_bottom}
			- {{2{in_ch.outer_top[31]}}, in_ch.outer_top}
			- {{2{min_gap_q[31]}}, min_gap_q});
	assign ca_in = {{2{in_ch.inner_center[31]}}, in_ch.inner_center}
		- {{2{in_ch.outer_center[31]}}, in_ch.outer_center}
		- {{2{offset_x_q[31]}}, offset_x_q};

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_fire    = out_valid_q && out_ch.ready;
	// Load the output register once the previous result has left or is leaving
	assign out_load    = (state_q == ST_OUT) && (!out_valid_q || out_ch.ready);

	// Route operands to the shared units by sequencer step
	always_comb begin
		mul_start    = 1'b0;
		mul_mcand    = '0;
		mul_mplier   = '0;
		div_start    = 1'b0;
		div_dividend = '0;
		div_divisor  = '0;
		unique case (state_q)
			ST_DD: begin
				mul_start  = !issued_q;
				mul_mcand  = W'($signed({1'b0, dt}));
				mul_mplier = sgx_pkg::MPL_W'(dt);
			end
			ST_AG: begin
				div_start    = !issued_q;
				div_dividend = {1'b0, gap_comp_q, 32'd0};
				div_divisor  = dd_q;
			end
			ST_AA: begin
				div_start    = !issued_q;
				div_dividend = {1'b0, align_comp_q, 32'd0};
				div_divisor  = dd_q;
			end
			ST_GP: begin
				mul_start  = !issued_q;
				mul_mcand  = W'(gap_lam_q);
				mul_mplier = {1'b0, alpha_g_q};
			end
			ST_XP: begin
				mul_start  = !issued_q;
				mul_mcand  = W'(align_lam_q);
				mul_mplier = {1'b0, alpha_a_q};
			end
			ST_GD: begin
				div_start    = !issued_q;
				div_dividend = num_abs;
				div_divisor  = den_g;
			end
			ST_XD: begin
				div_start    = !issued_q;
				div_dividend = num_abs;
				div_divisor  = den_a;
			end
			ST_GI, ST_XI: begin
				mul_start  = !issued_q;
				mul_mcand  = W'(dl_q);
				mul_mplier = sgx_pkg::MPL_W'(wi_q);
			end
			ST_GO, ST_XO: begin
				mul_start  = !issued_q;
				mul_mcand  = W'(dl_q);
				mul_mplier = sgx_pkg::MPL_W'(wo_q);
			end
			ST_IDLE, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_above_q   <= 1'b1;
			min_gap_q    <= '0;
			offset_x_q   <= '0;
			gap_comp_q   <= '0;
			align_comp_q <= '0;
			time_step_q  <= sgx_pkg::STEP_W'(65536);
		end else if (wr_en) begin
			unique case (wr_index)
				sgx_pkg::REG_IS_ABOVE:   is_above_q   <= wr_data[0];
				sgx_pkg::REG_MIN_GAP:    min_gap_q    <= wr_data;
				sgx_pkg::REG_OFFSET_X:   offset_x_q   <= wr_data;
				sgx_pkg::REG_GAP_COMP:   gap_comp_q   <= wr_data[sgx_pkg::COMP_W-1:0];
				sgx_pkg::REG_ALIGN_COMP: align_comp_q <= wr_data[sgx_pkg::COMP_W-1:0];
				sgx_pkg::REG_TIME_STEP:  time_step_q  <= wr_data[sgx_pkg::STEP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer, multipliers and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issued_q    <= 1'b0;
			gap_lam_q   <= '0;
			align_lam_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (out_fire) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_DD;
						// Clear applies before anything else
						if (in_ch.clear_multipliers) begin
							gap_lam_q   <= '0;
							align_lam_q <= '0;
						end
					end
				end
				ST_DD, ST_AG, ST_AA, ST_GP, ST_GD, ST_GI, ST_GO,
				ST_XP, ST_XD, ST_XI, ST_XO: begin
					if (!issued_q) begin
						issued_q <= 1'b1;
					end else if (mul_stat.done || div_stat.done) begin
						issued_q <= 1'b0;
						unique case (state_q)
							ST_DD: state_q <= ST_AG;
							ST_AG: state_q <= ST_AA;
							ST_AA: begin
								// No mobility: leave both arms untouched
								if (wsum == '0) state_q <= ST_OUT;
								else if (c_q[33]) state_q <= ST_GP;
								else begin
									gap_lam_q <= '0;
									state_q   <= ST_XP;
								end
							end
							ST_GP: state_q <= ST_GD;
							ST_GD: begin
								// Clamp at zero; applied change is new minus old
								gap_lam_q <= lam_sum[35] ? 32'sd0 : lam_new;
								state_q   <= ST_GI;
							end
							ST_GI: state_q <= ST_GO;
							ST_GO: state_q <= ST_XP;
							ST_XP: state_q <= ST_XD;
							ST_XD: begin
								align_lam_q <= lam_new;
								state_q     <= ST_XI;
							end
							ST_XI: state_q <= ST_XO;
							ST_XO: state_q <= ST_OUT;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_OUT: begin
					// Hold while the previous result still waits
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item payload and intermediate results
	always_ff @(posedge clk) begin
		if (in_fire) begin
			wi_q  <= in_ch.inner_mobility;
			wo_q  <= in_ch.outer_mobility;
			c_q   <= c_in;
			ca_q  <= ca_in;
			idy_q <= '0;
			ody_q <= '0;
			idx_q <= '0;
			odx_q <= '0;
		end
		if (issued_q && (mul_stat.done || div_stat.done)) begin
			unique case (state_q)
				ST_DD: dd_q      <= mul_prod[sgx_pkg::DSR_W-1:0];
				ST_AG: alpha_g_q <= alpha_new;
				ST_AA: alpha_a_q <= alpha_new;
				ST_GD: dl_q      <= 35'(lam_sum[35] ? 36'sd0 : 36'(lam_new))
					- 35'(gap_lam_q);
				ST_XD: dl_q      <= dl_new;
				ST_GI: idy_q     <= sgx_pkg::corr(mul_prod, is_above_q);
				ST_GO: ody_q     <= sgx_pkg::corr(mul_prod, !is_above_q);
				ST_XI: idx_q     <= sgx_pkg::corr(mul_prod, 1'b0);
				ST_XO: odx_q     <= sgx_pkg::corr(mul_prod, 1'b1);
				default: begin
				end
			endcase
		end
		if (out_load) begin
			o_idy_q  <= idy_q;
			o_ody_q  <= ody_q;
			o_idx_q  <= idx_q;
			o_odx_q  <= odx_q;
			o_viol_q <= c_q[33];
			o_res_q  <= sgx_pkg::sat32(W'(c_q));
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.inner_dy_delta = o_idy_q;
	assign out_ch.outer_dy_delta = o_ody_q;
	assign out_ch.inner_dx_delta = o_idx_q;
	assign out_ch.outer_dx_delta = o_odx_q;
	assign out_ch.gap_violated   = o_viol_q;
	assign out_ch.gap_residual   = o_res_q;

	// The gap multiplier is clamped at zero and never goes negative
	a_gap_lam_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!gap_lam_q[31]) else $error("gap multiplier negative");

	// A transfer in closes the input until the projection is done
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ch.ready) else $error("input reopened during projection");

	// Only one shared unit runs at a time
	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(mul_stat.busy && div_stat.busy)) else $error("multiplier and divider both busy");
endmodule

/* hdl/sgx_mul.sv */
// Bit-serial shift-add multiplier: signed multiplicand times unsigned multiplier.
// Depends on sgx_pkg.
module sgx_mul (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic signed [sgx_pkg::WIDE_W-1:0]     mcand,
	input  logic        [sgx_pkg::MPL_W-1:0]      mplier,
	output logic signed [sgx_pkg::WIDE_W-1:0]     prod,
	output sgx_pkg::unit_stat_t                   stat
);
	localparam int CNT_W = $clog2(sgx_pkg::MUL_STEPS);

	logic signed [sgx_pkg::WIDE_W-1:0] acc_q;
	logic signed [sgx_pkg::WIDE_W-1:0] mcand_q;
	logic        [sgx_pkg::MPL_W-1:0]  mplier_q;
	logic        [CNT_W-1:0]           cnt_q;
	logic                              busy_q;
	logic                              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(sgx_pkg::MUL_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q    <= '0;
			mcand_q  <= mcand;
			mplier_q <= mplier;
		end else if (busy_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

/* hdl/sgx_div.sv */
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on sgx_pkg.
module sgx_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sgx_pkg::WIDE_W-1:0]    dividend,
	input  logic [sgx_pkg::DSR_W-1:0]     divisor,
	output logic [sgx_pkg::WIDE_W-1:0]    quot,
	output sgx_pkg::unit_stat_t           stat
);
	localparam int CNT_W = $clog2(sgx_pkg::DIV_STEPS);
	localparam int REM_W = sgx_pkg::DSR_W + 1;

	logic [sgx_pkg::WIDE_W-1:0] dvd_q;
	logic [REM_W-1:0]           rem_q;
	logic [sgx_pkg::DSR_W-1:0]  dsr_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [REM_W-1:0]           rem_sh;
	logic                       ge;

	assign rem_sh = {rem_q[REM_W-2:0], dvd_q[sgx_pkg::WIDE_W-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(sgx_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
			dvd_q <= {dvd_q[sgx_pkg::WIDE_W-2:0], ge};
		end
	end

	assign quot      = dvd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;
endmodule

/* tb/sgx_projection_checker.sv */
`timescale 1ns / 100ps
// Checker for the stacking gap projector: watches the channels and the register port,
// predicts every result and compares it. Depends on sgx_pkg and the sgx_ifs interfaces.
module sgx_projection_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	sgx_in_if                              in_ch,
	sgx_out_if                             out_ch,
	input  logic                           wr_en,
	input  logic [sgx_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [sgx_pkg::CFG_DATA_W-1:0] wr_data,
	output int                             failures,
	output int                             outstanding,
	output int                             results_seen
);
	typedef struct {
		logic signed [31:0] inner_dy;
		logic signed [31:0] outer_dy;
		logic signed [31:0] inner_dx;
		logic signed [31:0] outer_dx;
		logic               violated;
		logic signed [31:0] residual;
	} correction_t;

	correction_t expected_corrections[$];

	logic               stack_above;
	logic signed [31:0] gap_floor;
	logic signed [31:0] center_offset;
	logic [30:0]        gap_soft;
	logic [30:0]        align_soft;
	logic [16:0]        substep;
	logic signed [31:0] gap_lambda;
	logic signed [31:0] align_lambda;

	assign outstanding = expected_corrections.size();

	function automatic logic signed [31:0] clip32(input longint v);
		if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
		if (v < -64'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// compliance / dt^2 in Q16.16, saturated
	function automatic longint softness(input logic [30:0] comp);
		longint unsigned d;
		longint unsigned q;
		d = (substep == 17'd0) ? 64'd1 : longint'(substep);
		q = (longint'(comp) << 32) / (d * d);
		return (q > 64'h7FFF_FFFF) ? 64'sh7FFF_FFFF : longint'(q);
	endfunction

	function automatic longint lambda_change(input longint c, input longint alpha,
		input logic signed [31:0] lam, input longint wsum);
		longint num;
		longint q;
		num = -(c * 65536) - alpha * longint'(lam);
		q = num / (wsum + alpha);
		if (q > 64'sd8589934592) q = 64'sd8589934592;
		if (q < -64'sd8589934592) q = -64'sd8589934592;
		return q;
	endfunction

	function automatic logic signed [31:0] shift_of(input longint w, input longint dl);
		return clip32((w * dl) / 65536);
	endfunction

	function automatic correction_t project();
		correction_t r;
		longint wi, wo, c, ca, alpha, dl, nl;
		logic signed [31:0] lam;
		r = '{default: '0};
		wi = longint'(in_ch.inner_mobility);
		wo = longint'(in_ch.outer_mobility);
		if (in_ch.clear_multipliers) begin
			gap_lambda = '0;
			align_lambda = '0;
		end
		c = stack_above ? longint'(in_ch.outer_bottom) - longint'(in_ch.inner_top)
			: longint'(in_ch.inner_bottom) - longint'(in_ch.outer_top);
		c = c - longint'(gap_floor);
		if (wi + wo > 0) begin
			if (c < 0) begin
				alpha = softness(gap_soft);
				if (wi + wo + alpha > 0) begin
					dl = lambda_change(c, alpha, gap_lambda, wi + wo);
					nl = longint'(gap_lambda) + dl;
					if (nl < 0) nl = 0;
					lam = clip32(nl);
					// apply only what the clamp let through
					dl = longint'(lam) - longint'(gap_lambda);
					gap_lambda = lam;
					r.inner_dy = shift_of(wi, stack_above ? -dl : dl);
					r.outer_dy = shift_of(wo, stack_above ? dl : -dl);
				end
			end else begin
				gap_lambda = '0;
			end
			ca = longint'(in_ch.inner_center) - longint'(in_ch.outer_center)
				- longint'(center_offset);
			alpha = softness(align_soft);
			if (wi + wo + alpha > 0) begin
				dl = lambda_change(ca, alpha, align_lambda, wi + wo);
				align_lambda = clip32(longint'(align_lambda) + dl);
				r.inner_dx = shift_of(wi, dl);
				r.outer_dx = shift_of(wo, -dl);
			end
		end
		r.violated = (c < 0);
		r.residual = clip32(c);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		correction_t want;
		if (!arst_n) begin
			stack_above = 1'b1;
			gap_floor = '0;
			center_offset = '0;
			gap_soft = '0;
			align_soft = '0;
			substep = 17'd65536;
			gap_lambda = '0;
			align_lambda = '0;
			failures <= 0;
			results_seen <= 0;
			expected_corrections.delete();
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				results_seen <= results_seen + 1;
				if (expected_corrections.size() == 0) begin
					failures <= failures + 1;
					if (failures < 10) $display("%t: result with nothing expected", $realtime);
				end else begin
					want = expected_corrections.pop_front();
					if (want.inner_dy !== out_ch.inner_dy_delta
						|| want.outer_dy !== out_ch.outer_dy_delta
						|| want.inner_dx !== out_ch.inner_dx_delta
						|| want.outer_dx !== out_ch.outer_dx_delta
						|| want.violated !== out_ch.gap_violated
						|| want.residual !== out_ch.gap_residual) begin
						failures <= failures + 1;
						if (failures < 10)
							$display("%t: mismatch exp dy %0d/%0d dx %0d/%0d v%0d r%0d got dy %0d/%0d dx %0d/%0d v%0d r%0d",
								$realtime, want.inner_dy, want.outer_dy, want.inner_dx,
								want.outer_dx, want.violated, want.residual,
								out_ch.inner_dy_delta, out_ch.outer_dy_delta,
								out_ch.inner_dx_delta, out_ch.outer_dx_delta,
								out_ch.gap_violated, out_ch.gap_residual);
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_corrections = {expected_corrections, project()};
			if (wr_en) begin
				case (wr_index)
					sgx_pkg::REG_IS_ABOVE:   stack_above = wr_data[0];
					sgx_pkg::REG_MIN_GAP:    gap_floor = wr_data;
					sgx_pkg::REG_OFFSET_X:   center_offset = wr_data;
					sgx_pkg::REG_GAP_COMP:   gap_soft = wr_data[30:0];
					sgx_pkg::REG_ALIGN_COMP: align_soft = wr_data[30:0];
					sgx_pkg::REG_TIME_STEP:  substep = wr_data[16:0];
					default: ;
				endcase
			end
		end
	end
endmodule

/* tb/stack_gap_xpbd_projector_test.sv */
`timescale 1ns / 100ps
// Top of the stacking gap projector testbench: clock, reset, stimulus and verdict.
// Depends on sgx_pkg, sgx_ifs, the projector itself and sgx_projection_checker.
module stack_gap_xpbd_projector_test;
	typedef struct {
		logic               clr;
		logic [24:0]        wi;
		logic [24:0]        wo;
		logic signed [31:0] it, ib, ic, ot, ob, oc;
	} box_pair_t;

	logic                           clk;
	logic                           arst_n;
	logic                           wr_en;
	logic [sgx_pkg::CFG_IDX_W-1:0]  wr_index;
	logic [sgx_pkg::CFG_DATA_W-1:0] wr_data;
	int                             failures;
	int                             outstanding;
	int                             results_seen;
	int                             projections_sent;
	int                             settings_used;
	// drop all idling while this is set
	logic                           quiet;
	logic signed [31:0]             cur_gap;
	logic signed [31:0]             cur_offset;

	sgx_in_if  in_ch();
	sgx_out_if out_ch();

	stack_gap_xpbd_projector dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	sgx_projection_checker checker_i (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
		.failures(failures), .outstanding(outstanding), .results_seen(results_seen)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Result side: stall about 6 percent of the time at random unless quiet.
	always @(posedge clk)
		out_ch.ready <= quiet || ($urandom_range(0, 99) >= 6);

	function automatic box_pair_t pair(input logic clr, input logic [24:0] wi,
		input logic [24:0] wo, input int it, input int ib, input int ic,
		input int ot, input int ob, input int oc);
		box_pair_t p;
		p.clr = clr; p.wi = wi; p.wo = wo;
		p.it = it; p.ib = ib; p.ic = ic; p.ot = ot; p.ob = ob; p.oc = oc;
		return p;
	endfunction

	function automatic int jitter(input int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Mostly boxes near the current gap and offset: small alignment residuals of
	// either sign, and gap ones when outer is above; the rest is full-range noise.
	function automatic box_pair_t stacked_pair();
		box_pair_t p;
		int base, span;
		span = 1 << $urandom_range(8, 22);
		p.clr = ($urandom_range(0, 9) == 0);
		case ($urandom_range(0, 9))
			0:       begin p.wi = '0; p.wo = '0; end
			1:       begin p.wi = 25'd16777216; p.wo = 25'($urandom_range(0, 16777216)); end
			2:       begin p.wi = 25'($urandom_range(0, 16777216)); p.wo = '0; end
			default: begin
				p.wi = 25'($urandom_range(0, 1 << 18));
				p.wo = 25'($urandom_range(0, 1 << 18));
			end
		endcase
		if ($urandom_range(0, 99) < 80) begin
			base = jitter(1 << 26);
			p.it = base;
			p.ib = base + int'($urandom_range(0, 1 << 22));
			p.ot = p.ib + cur_gap + jitter(span);
			p.ob = p.it + cur_gap + jitter(span);
			p.oc = jitter(1 << 26);
			p.ic = p.oc + cur_offset + jitter(span);
		end else begin
			p.it = $urandom; p.ib = $urandom; p.ic = $urandom;
			p.ot = $urandom; p.ob = $urandom; p.oc = $urandom;
		end
		return p;
	endfunction

	// Hold valid high across back-to-back items; lower it only for a gap.
	task automatic send(input box_pair_t p);
		if (!quiet && $urandom_range(0, 99) < 6) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_ch.clear_multipliers <= p.clr;
		in_ch.inner_mobility <= p.wi;
		in_ch.outer_mobility <= p.wo;
		in_ch.inner_top <= p.it;
		in_ch.inner_bottom <= p.ib;
		in_ch.inner_center <= p.ic;
		in_ch.outer_top <= p.ot;
		in_ch.outer_bottom <= p.ob;
		in_ch.outer_center <= p.oc;
		in_ch.valid <= 1'b1;
		do @(posedge clk); while (!in_ch.ready);
		projections_sent++;
	endtask

	// Idle the input, then wait until every projection in flight has come back.
	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic above, input logic [31:0] gap,
		input logic [31:0] offs, input logic [31:0] gsoft, input logic [31:0] asoft,
		input logic [31:0] dt);
		logic [sgx_pkg::CFG_IDX_W-1:0] idx [6];
		logic [31:0]                   val [6];
		idx = '{sgx_pkg::REG_IS_ABOVE, sgx_pkg::REG_MIN_GAP, sgx_pkg::REG_OFFSET_X,
			sgx_pkg::REG_GAP_COMP, sgx_pkg::REG_ALIGN_COMP, sgx_pkg::REG_TIME_STEP};
		val = '{{31'd0, above}, gap, offs, gsoft, asoft, dt};
		for (int k = 0; k < 6; k++) begin
			wr_en <= 1'b1;
			wr_index <= idx[k];
			wr_data <= val[k];
			@(posedge clk);
		end
		wr_en <= 1'b0;
		@(posedge clk);
		cur_gap = gap;
		cur_offset = offs;
		settings_used++;
	endtask

	task automatic random_phase(input int count, input int first);
		for (int n = 0; n < count; n++) begin
			// long stretch without idling on either side
			quiet = (first + n >= 500) && (first + n < 900);
			send(stacked_pair());
		end
		quiet = 1'b0;
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		quiet = 1'b0;
		cur_gap = '0;
		cur_offset = '0;
		projections_sent = 0;
		settings_used = 0;
		in_ch.valid = 1'b0;
		in_ch.clear_multipliers = 1'b0;
		in_ch.inner_mobility = '0;
		in_ch.outer_mobility = '0;
		in_ch.inner_top = '0;
		in_ch.inner_bottom = '0;
		in_ch.inner_center = '0;
		in_ch.outer_top = '0;
		in_ch.outer_bottom = '0;
		in_ch.outer_center = '0;
		out_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset defaults first, then compliant arms.
		send(pair(1'b0, 25'd65536, 25'd65536, 0, 0, 0, 32'sh0001_0000, -65536, 65536));
		send(pair(1'b0, 25'd65536, 25'd131072, 65536, 0, 0, 0, 0, 0));
		// no mobility, with and without the clear flag
		send(pair(1'b1, 25'd0, 25'd0, 65536, 0, 5, 0, 0, -5));
		send(pair(1'b0, 25'd0, 25'd0, -65536, 0, 0, 0, 0, 0));
		// gap satisfied then violated again
		send(pair(1'b0, 25'd16777216, 25'd0, 0, 0, 32'sh7FFF_FFFF, 0, 32'sh0010_0000,
			32'sh8000_0000));
		send(pair(1'b0, 25'd0, 25'd16777216, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0,
			32'sh8000_0000, 32'sh7FFF_FFFF));
		send(pair(1'b1, 25'd16777216, 25'd16777216, 32'sh8000_0000, 32'sh7FFF_FFFF, -1,
			32'sh7FFF_FFFF, 32'sh8000_0000, -1));
		send(pair(1'b0, 25'd1, 25'd1, 32'sh7FFF_FFFF, 32'sh8000_0000, 0,
			32'sh8000_0000, 32'sh7FFF_FFFF, 0));
		send(pair(1'b0, 25'h1FF_FFFF & 25'd16777216, 25'd1, -1, -1, -1, -1, -1, -1));
		drain();
		// compliant arms, inner above outer, zero time step
		write_regs(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0);
		send(pair(1'b1, 25'd65536, 25'd65536, 0, 32'sh7FFF_FFFF, 0, 32'sh8000_0000, 0, 0));
		send(pair(1'b0, 25'd65536, 25'd65536, 0, 0, 32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000));
		send(pair(1'b0, 25'd0, 25'd0, 0, 0, 0, 0, 0, 0));
		drain();
		write_regs(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd65536, 32'd1, 32'h1FFFF);
		send(pair(1'b0, 25'd16777216, 25'd16777216, 32'sh7FFF_FFFF, 0, 32'sh8000_0000,
			0, 32'sh8000_0000, 32'sh7FFF_FFFF));
		send(pair(1'b0, 25'd3, 25'd0, 0, 0, 0, 0, 0, 0));
		send(pair(1'b1, 25'd0, 25'd7, 100, 0, 100, 0, -100, -100));
		drain();

		// Random phases, each under its own register setting.
		write_regs(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536);
		random_phase(258, 0);
		write_regs(1'b0, 32'h0005_0000, 32'hFFFD_0000, 32'h0000_8000, 32'h0000_4000,
			32'h4000);
		random_phase(258, 258);
		write_regs(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'd1);
		random_phase(258, 516);
		write_regs(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0);
		random_phase(258, 774);
		write_regs(1'b1, $urandom_range(0, 1 << 20), $urandom, $urandom_range(0, 1 << 16),
			$urandom, 32'h1FFFF);
		random_phase(258, 1032);
		write_regs(1'b0, 32'hFFFE_0000, 32'h0001_0000, 32'h0001_0000, 32'h0000_0100,
			32'h8000);
		random_phase(258, 1290);

		// let the block settle for about one projection's latency
		repeat (600) @(posedge clk);
		$display("Run covered %0d projections and %0d results under %0d register settings.",
			projections_sent, results_seen, settings_used);
		if (failures == 0 && outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	initial begin
		#200_000_000;
		$display("Timed out with %0d results outstanding.", outstanding);
		$display("CHECKS FAILED");
		$finish;
	end
endmodule
